// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic       CFG_TICKS   = 1'b0;
  localparam logic       CFG_TIMEOUT = 1'b1;

  localparam logic [15:0] TICKS_RESET   = 16'd1;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd250;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       ready_res;
    logic       cmd_done;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/i2cm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cm_queue
  import i2cm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      q_valid,
  input  wire logic q_pop,
  output in_t       q_data
);

  in_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_stall = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i2cm_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cm_engine
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] ticks_cfg,
  input  wire logic [7:0]  timeout_cfg,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire in_t         q_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data
);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_S1   = 4'd1;
  localparam logic [3:0] PH_S2   = 4'd2;
  localparam logic [3:0] PH_P1   = 4'd3;
  localparam logic [3:0] PH_P2   = 4'd4;
  localparam logic [3:0] PH_WL   = 4'd5;
  localparam logic [3:0] PH_WH   = 4'd6;
  localparam logic [3:0] PH_AL   = 4'd7;
  localparam logic [3:0] PH_AH   = 4'd8;
  localparam logic [3:0] PH_POLL = 4'd9;
  localparam logic [3:0] PH_RL   = 4'd10;
  localparam logic [3:0] PH_RH   = 4'd11;
  localparam logic [3:0] PH_KL   = 4'd12;
  localparam logic [3:0] PH_KH   = 4'd13;

  localparam logic [2:0] LV_SCL = 3'b001;
  localparam logic [2:0] LV_SDA = 3'b010;
  localparam logic [2:0] LV_DRV = 3'b100;

  logic [3:0]  phase_r, phase_nxt;
  logic [19:0] dly_r, dly_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        ackc_r, ackc_nxt;
  logic [2:0]  lv_r, lv_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        fail_r, fail_nxt;
  logic        done;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;
  logic [19:0] t_ext;
  logic [19:0] d1, d2, d5;

  assign t_ext = {4'd0, (ticks_cfg == 16'd0) ? 16'd1 : ticks_cfg};
  assign d1    = t_ext - 20'd1;
  assign d2    = (t_ext << 1) - 20'd1;
  assign d5    = (t_ext << 2) + t_ext - 20'd1;

  function automatic logic [2:0] fix_lv(input logic [2:0] lv);
    fix_lv = lv[2] ? lv : (lv | LV_SDA);
  endfunction

  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    phase_nxt = phase_r;
    dly_nxt   = dly_r;
    bit_nxt   = bit_r;
    sh_nxt    = sh_r;
    poll_nxt  = poll_r;
    ackc_nxt  = ackc_r;
    lv_nxt    = lv_r;
    rx_nxt    = rx_r;
    fail_nxt  = fail_r;
    done      = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (q_data.cmd_valid) begin
        unique case (q_data.opcode)
          OP_START: begin
            phase_nxt = PH_S1; dly_nxt = d5; lv_nxt = LV_SCL | LV_SDA | LV_DRV;
          end
          OP_STOP: begin
            phase_nxt = PH_P1; dly_nxt = d5; lv_nxt = LV_DRV;
          end
          OP_WRITE: begin
            fail_nxt  = 1'b0;
            sh_nxt    = q_data.tx_byte;
            bit_nxt   = 4'd0;
            phase_nxt = PH_WL;
            dly_nxt   = d2;
            lv_nxt    = LV_DRV | (q_data.tx_byte[7] ? LV_SDA : 3'b000);
          end
          default: begin
            sh_nxt    = 8'd0;
            bit_nxt   = 4'd0;
            ackc_nxt  = q_data.send_ack;
            phase_nxt = PH_RL;
            dly_nxt   = d2;
            lv_nxt    = fix_lv(3'b000);
          end
        endcase
      end
    end else if (phase_r == PH_POLL) begin
      if (!q_data.sda_in) begin
        lv_nxt    = lv_r & ~LV_SCL;
        phase_nxt = PH_IDLE;
        done      = 1'b1;
      end else if (poll_r >= timeout_cfg) begin
        fail_nxt  = 1'b1;
        phase_nxt = PH_P1;
        dly_nxt   = d5;
        lv_nxt    = LV_DRV;
      end else begin
        poll_nxt = poll_r + 8'd1;
      end
    end else if (dly_r != 20'd0) begin
      dly_nxt = dly_r - 20'd1;
    end else begin
      unique case (phase_r)
        PH_S1: begin
          phase_nxt = PH_S2; dly_nxt = d2; lv_nxt = LV_SCL | LV_DRV;
        end
        PH_S2: begin
          lv_nxt = lv_r & ~LV_SCL; phase_nxt = PH_IDLE; done = 1'b1;
        end
        PH_P1: begin
          phase_nxt = PH_P2; dly_nxt = d5; lv_nxt = LV_SCL | LV_SDA | LV_DRV;
        end
        PH_P2: begin
          phase_nxt = PH_IDLE; done = 1'b1;
        end
        PH_WL, PH_KL: begin
          phase_nxt = (phase_r == PH_WL) ? PH_WH : PH_KH;
          dly_nxt   = d2;
          lv_nxt    = fix_lv(lv_r | LV_SCL);
        end
        PH_WH: begin
          bit_nxt = bit_r + 4'd1;
          dly_nxt = d2;
          if (bit_nxt < 4'd8) begin
            sh_nxt    = {sh_r[6:0], 1'b0};
            phase_nxt = PH_WL;
            lv_nxt    = LV_DRV | (sh_r[6] ? LV_SDA : 3'b000);
          end else begin
            phase_nxt = PH_AL;
            lv_nxt    = fix_lv(3'b000);
          end
        end
        PH_AL: begin
          phase_nxt = PH_AH; dly_nxt = d2; lv_nxt = fix_lv(LV_SCL);
        end
        PH_AH: begin
          phase_nxt = PH_POLL; poll_nxt = 8'd0;
        end
        PH_RL: begin
          phase_nxt = PH_RH;
          dly_nxt   = d1;
          lv_nxt    = fix_lv(LV_SCL);
          sh_nxt    = {sh_r[6:0], q_data.sda_in};
          bit_nxt   = bit_r + 4'd1;
        end
        PH_RH: begin
          dly_nxt = d2;
          if (bit_r < 4'd8) begin
            phase_nxt = PH_RL;
            lv_nxt    = fix_lv(3'b000);
          end else begin
            phase_nxt = PH_KL;
            lv_nxt    = LV_DRV | (ackc_r ? 3'b000 : LV_SDA);
          end
        end
        PH_KH: begin
          lv_nxt    = lv_r & ~LV_SCL;
          rx_nxt    = sh_r;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.scl_out    = lv_nxt[0];
      out_data_nxt.sda_out    = lv_nxt[1];
      out_data_nxt.sda_drive  = lv_nxt[2];
      out_data_nxt.ready_res  = (phase_nxt == PH_IDLE);
      out_data_nxt.cmd_done   = done;
      out_data_nxt.rx_byte    = rx_nxt;
      out_data_nxt.ack_failed = fail_nxt;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      dly_r       <= 20'd0;
      bit_r       <= 4'd0;
      sh_r        <= 8'd0;
      poll_r      <= 8'd0;
      ackc_r      <= 1'b0;
      lv_r        <= LV_SCL | LV_SDA | LV_DRV;
      rx_r        <= 8'd0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        dly_r   <= dly_nxt;
        bit_r   <= bit_nxt;
        sh_r    <= sh_nxt;
        poll_r  <= poll_nxt;
        ackc_r  <= ackc_nxt;
        lv_r    <= lv_nxt;
        rx_r    <= rx_nxt;
        fail_r  <= fail_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/i2c_bit_level_master.sv =====
// Byte-level I2C master timing engine. Each input transaction is one tick: it may
// carry a command (start, stop, write byte, read byte) and always carries the
// sampled SDA level. Each tick yields exactly one output transaction with the
// SCL and SDA drive levels, ready, done, the last received byte and the
// acknowledge-failure flag.
// Input transactions enter a two-entry queue; the engine takes one per cycle while
// the output register is empty or not stalled and places its result there, so one
// transaction per cycle is sustained via the queue and then the output register.
// When the receiver stalls, the output register holds its result, the engine
// pauses and the queue fills; in_stall rises once the queue is full.
// The configuration port (cfg_we, cfg_idx, cfg_wdata) sets the ticks per delay
// unit (index 0) and the acknowledge timeout (index 1); write it only when idle.
// Synchronous reset empties the queue and output register, sets the engine idle
// with SCL and SDA driven high, and restores one tick per unit and timeout 250.
`timescale 1ns / 1ps
`default_nettype none
module i2c_bit_level_master
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] ticks_r;
  logic [7:0]  timeout_r;
  logic        q_valid;
  logic        q_pop;
  in_t         q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r   <= TICKS_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_TICKS) begin
        ticks_r <= cfg_wdata;
      end else begin
        timeout_r <= cfg_wdata[7:0];
      end
    end
  end

  i2cm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  i2cm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .ticks_cfg   (ticks_r),
    .timeout_cfg (timeout_r),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (q_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_START_HI, BUS_START_LO, BUS_STOP_LO, BUS_STOP_HI,
    BUS_WR_LO, BUS_WR_HI, BUS_ACK_LO, BUS_ACK_HI, BUS_ACK_POLL,
    BUS_RD_LO, BUS_RD_HI, BUS_NAK_LO, BUS_NAK_HI
  } bus_state_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CFG_TICKS;
  logic [15:0] cfg_wdata = '0;

  i2c_bit_level_master u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  in_t  tick_queue[$];
  out_t line_expect[$];
  int   errors = 0;
  bit   gaps_on = 1'b1;

  // Bus engine state as predicted from accepted ticks.
  bus_state_e  bus_st = BUS_IDLE;
  logic [19:0] seg_count = '0;
  logic [3:0]  bit_num = '0;
  logic [7:0]  shifter = '0;
  logic [7:0]  poll_num = '0;
  logic        ack_sel = 1'b0;
  logic        lv_scl = 1'b1, lv_sda = 1'b1, lv_drv = 1'b1;
  logic [7:0]  rx_last = '0;
  logic        nack_seen = 1'b0;
  logic [15:0] unit_ticks = TICKS_RESET;
  logic [7:0]  poll_limit = TIMEOUT_RESET;

  function automatic void enter_seg(bus_state_e s, int units, logic scl, logic sda,
                                    logic drv);
    int t;
    t = (unit_ticks == 0) ? 1 : unit_ticks;
    bus_st = s;
    seg_count = 20'(units * t - 1);
    lv_scl = scl;
    lv_drv = drv;
    lv_sda = drv ? sda : 1'b1;
  endfunction

  function automatic out_t bus_tick(in_t it);
    out_t r;
    logic done;
    done = 1'b0;
    if (bus_st == BUS_IDLE) begin
      if (it.cmd_valid) begin
        case (it.opcode)
          OP_START: enter_seg(BUS_START_HI, 5, 1'b1, 1'b1, 1'b1);
          OP_STOP: enter_seg(BUS_STOP_LO, 5, 1'b0, 1'b0, 1'b1);
          OP_WRITE: begin
            nack_seen = 1'b0;
            shifter = it.tx_byte;
            bit_num = '0;
            enter_seg(BUS_WR_LO, 2, 1'b0, shifter[7], 1'b1);
          end
          default: begin
            shifter = '0;
            bit_num = '0;
            ack_sel = it.send_ack;
            enter_seg(BUS_RD_LO, 2, 1'b0, 1'b0, 1'b0);
          end
        endcase
      end
    end else if (bus_st == BUS_ACK_POLL) begin
      if (!it.sda_in) begin
        lv_scl = 1'b0;
        bus_st = BUS_IDLE;
        done = 1'b1;
      end else if (poll_num >= poll_limit) begin
        nack_seen = 1'b1;
        enter_seg(BUS_STOP_LO, 5, 1'b0, 1'b0, 1'b1);
      end else begin
        poll_num = poll_num + 8'd1;
      end
    end else if (seg_count != 0) begin
      seg_count = seg_count - 20'd1;
    end else begin
      case (bus_st)
        BUS_START_HI: enter_seg(BUS_START_LO, 2, 1'b1, 1'b0, 1'b1);
        BUS_START_LO: begin
          lv_scl = 1'b0;
          bus_st = BUS_IDLE;
          done = 1'b1;
        end
        BUS_STOP_LO: enter_seg(BUS_STOP_HI, 5, 1'b1, 1'b1, 1'b1);
        BUS_STOP_HI: begin
          bus_st = BUS_IDLE;
          done = 1'b1;
        end
        BUS_WR_LO: enter_seg(BUS_WR_HI, 2, 1'b1, lv_sda, lv_drv);
        BUS_WR_HI: begin
          bit_num = bit_num + 4'd1;
          if (bit_num < 8) begin
            shifter = shifter << 1;
            enter_seg(BUS_WR_LO, 2, 1'b0, shifter[7], 1'b1);
          end else begin
            enter_seg(BUS_ACK_LO, 2, 1'b0, 1'b0, 1'b0);
          end
        end
        BUS_ACK_LO: enter_seg(BUS_ACK_HI, 2, 1'b1, 1'b0, 1'b0);
        BUS_ACK_HI: begin
          bus_st = BUS_ACK_POLL;
          poll_num = '0;
        end
        BUS_RD_LO: begin
          enter_seg(BUS_RD_HI, 1, 1'b1, 1'b0, 1'b0);
          shifter = {shifter[6:0], it.sda_in};
          bit_num = bit_num + 4'd1;
        end
        BUS_RD_HI: begin
          if (bit_num < 8) enter_seg(BUS_RD_LO, 2, 1'b0, 1'b0, 1'b0);
          else enter_seg(BUS_NAK_LO, 2, 1'b0, !ack_sel, 1'b1);
        end
        BUS_NAK_LO: enter_seg(BUS_NAK_HI, 2, 1'b1, lv_sda, lv_drv);
        BUS_NAK_HI: begin
          lv_scl = 1'b0;
          rx_last = shifter;
          bus_st = BUS_IDLE;
          done = 1'b1;
        end
        default: bus_st = BUS_IDLE;
      endcase
    end
    r.scl_out = lv_scl;
    r.sda_out = lv_sda;
    r.sda_drive = lv_drv;
    r.ready_res = (bus_st == BUS_IDLE);
    r.cmd_done = done;
    r.rx_byte = rx_last;
    r.ack_failed = nack_seen;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (!gaps_on || p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        line_expect.push_back(bus_tick(in_data));
        send_gap = pick_gap();
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0 || tick_queue.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        in_data <= tick_queue.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  function automatic void check_line(out_t e, out_t a);
    if (a.scl_out !== e.scl_out) begin
      $error("scl_out expected %0d got %0d", e.scl_out, a.scl_out);
      errors++;
    end
    if (a.sda_out !== e.sda_out) begin
      $error("sda_out expected %0d got %0d", e.sda_out, a.sda_out);
      errors++;
    end
    if (a.sda_drive !== e.sda_drive) begin
      $error("sda_drive expected %0d got %0d", e.sda_drive, a.sda_drive);
      errors++;
    end
    if (a.ready_res !== e.ready_res) begin
      $error("ready_res expected %0d got %0d", e.ready_res, a.ready_res);
      errors++;
    end
    if (a.cmd_done !== e.cmd_done) begin
      $error("cmd_done expected %0d got %0d", e.cmd_done, a.cmd_done);
      errors++;
    end
    if (a.rx_byte !== e.rx_byte) begin
      $error("rx_byte expected %0h got %0h", e.rx_byte, a.rx_byte);
      errors++;
    end
    if (a.ack_failed !== e.ack_failed) begin
      $error("ack_failed expected %0d got %0d", e.ack_failed, a.ack_failed);
      errors++;
    end
  endfunction

  int received = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit hold_taken = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        received++;
        if (line_expect.size() == 0) begin
          $error("result transaction arrived with none expected");
          errors++;
        end else begin
          check_line(line_expect.pop_front(), out_data);
        end
      end
      // One long hold-off so that the block fills up and stalls its input.
      if (!hold_taken && received >= 300) begin
        hold_taken = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (gaps_on && $urandom_range(99) < 15) stall_left = pick_gap();
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_t rand_tick(int cmd_pct);
    in_t it;
    it.cmd_valid = ($urandom_range(99) < cmd_pct);
    it.opcode = 2'($urandom_range(3));
    it.tx_byte = 8'($urandom);
    it.send_ack = 1'($urandom_range(1));
    it.sda_in = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic push_cmd(logic [1:0] op, logic [7:0] tx, logic ack, int sda_mode,
                          int fill);
    in_t it;
    it = '{cmd_valid: 1'b1, opcode: op, tx_byte: tx, send_ack: ack, sda_in: 1'b1};
    tick_queue.push_back(it);
    repeat (fill) begin
      it = rand_tick(10);
      if (sda_mode == 0) it.sda_in = 1'b0;
      else if (sda_mode == 1) it.sda_in = 1'b1;
      tick_queue.push_back(it);
    end
  endtask

  task automatic drain();
    in_t it;
    forever begin
      do @(negedge clk);
      while (tick_queue.size() != 0 || in_valid || line_expect.size() != 0);
      if (bus_st == BUS_IDLE) break;
      it = rand_tick(0);
      it.sda_in = 1'b0;
      tick_queue.push_back(it);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TICKS) unit_ticks = val;
    else poll_limit = val[7:0];
    @(negedge clk);
  endtask

  int tick_set[7] = '{1, 2, 3, 65535, 0, 1, 1};
  int limit_set[7] = '{3, 0, 255, 1, 1, 250, 2};
  int ticks_n;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_cmd(OP_START, 8'h00, 1'b0, 1, 12);
    push_cmd(OP_WRITE, 8'hFF, 1'b0, 0, 45);
    push_cmd(OP_WRITE, 8'h00, 1'b1, 0, 45);
    push_cmd(OP_WRITE, 8'hA5, 1'b0, 1, 300);
    push_cmd(OP_READ, 8'h00, 1'b1, 2, 40);
    push_cmd(OP_READ, 8'hFF, 1'b0, 1, 40);
    push_cmd(OP_READ, 8'h00, 1'b1, 0, 40);
    push_cmd(OP_STOP, 8'h00, 1'b0, 2, 15);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_TICKS, 16'(tick_set[ph]));
      write_reg(CFG_TIMEOUT, 16'(limit_set[ph]) | (16'($urandom) & 16'hFF00));
      gaps_on = (ph != 2);
      ticks_n = (tick_set[ph] == 65535) ? 40 : 100;
      repeat (ticks_n) tick_queue.push_back(rand_tick(tick_set[ph] == 65535 ? 0 : 25));
      drain();
    end

    if (line_expect.size() != 0) begin
      $error("%0d result transactions never arrived", line_expect.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_queue.sv
rtl/i2cm_engine.sv
rtl/i2c_bit_level_master.sv
test/tb_top.sv
